>>> rtl/lpca_pkg.sv
package lpca_pkg;

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_BODY   = 2'd1,
        PH_READY  = 2'd2,
        PH_ERROR  = 2'd3
    } phase_t;

    localparam logic OP_BYTE    = 1'b0;
    localparam logic OP_CONSUME = 1'b1;

    localparam logic [1:0] CODE_OK    = 2'd0;
    localparam logic [1:0] CODE_SMALL = 2'd1;
    localparam logic [1:0] CODE_LARGE = 2'd2;

    localparam int LEN_W        = 32;
    localparam int LEN_FIRST    = 2;
    localparam int LEN_LAST     = 5;
    localparam int INDEX_W      = 12;
    localparam int CMD_LEN_W    = 13;

    typedef struct packed {
        logic                   store_valid;
        logic [INDEX_W-1:0]     store_index;
        logic [7:0]             store_data;
        logic                   frame_done;
        logic                   command_taken;
        logic [CMD_LEN_W-1:0]   command_length;
        logic [1:0]             status_code;
    } result_t;

endpackage

>>> rtl/lpca_frame.sv
module lpca_frame #(
    parameter int HEADER_LEN  = 10,
    parameter int MAX_CMD_LEN = 4096
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic                op,
    input  logic [7:0]          rx_byte,
    output lpca_pkg::result_t   result
);

    localparam int CNT_W = $clog2(MAX_CMD_LEN + 1);

    lpca_pkg::phase_t                 phase_reg, phase_next;
    logic [CNT_W-1:0]                 count_reg, count_next;
    logic [lpca_pkg::LEN_W-1:0]       len_reg, len_next;
    logic [1:0]                       err_reg, err_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= lpca_pkg::PH_HEADER;
            count_reg <= '0;
            len_reg   <= '0;
            err_reg   <= lpca_pkg::CODE_OK;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            len_reg   <= len_next;
            err_reg   <= err_next;
        end
    end

    always_comb
    begin
        logic [lpca_pkg::LEN_W-1:0] idx32;
        logic [lpca_pkg::LEN_W-1:0] cnt32;
        logic [1:0]                 chk;

        phase_next = phase_reg;
        count_next = count_reg;
        len_next   = len_reg;
        err_next   = err_reg;
        result     = '0;

        idx32 = lpca_pkg::LEN_W'(count_reg);
        cnt32 = idx32 + 32'd1;
        chk   = lpca_pkg::CODE_OK;

        if (op == lpca_pkg::OP_BYTE)
        begin
            if (phase_reg == lpca_pkg::PH_HEADER || phase_reg == lpca_pkg::PH_BODY)
            begin
                result.store_valid = 1'b1;
                result.store_index = idx32[lpca_pkg::INDEX_W-1:0];
                result.store_data  = rx_byte;
                count_next         = count_reg + CNT_W'(1);

                if (phase_reg == lpca_pkg::PH_HEADER)
                begin
                    if (idx32 >= 32'(lpca_pkg::LEN_FIRST)
                        && idx32 <= 32'(lpca_pkg::LEN_LAST))
                    begin
                        len_next = {len_reg[23:0], rx_byte};
                    end
                    if (cnt32 == 32'(HEADER_LEN))
                    begin
                        if (len_next < 32'(HEADER_LEN))
                        begin
                            chk = lpca_pkg::CODE_SMALL;
                        end
                        else if (len_next > 32'(MAX_CMD_LEN))
                        begin
                            chk = lpca_pkg::CODE_LARGE;
                        end
                        err_next = chk;
                        if (chk != lpca_pkg::CODE_OK)
                        begin
                            phase_next = lpca_pkg::PH_ERROR;
                        end
                        else if (len_next == 32'(HEADER_LEN))
                        begin
                            phase_next = lpca_pkg::PH_READY;
                        end
                        else
                        begin
                            phase_next = lpca_pkg::PH_BODY;
                        end
                    end
                end
                else if (cnt32 == len_reg)
                begin
                    phase_next = lpca_pkg::PH_READY;
                end
            end
            result.status_code = err_next;
        end
        else
        begin
            result.status_code = err_reg;
            if (phase_reg == lpca_pkg::PH_READY)
            begin
                result.command_taken  = 1'b1;
                result.command_length = idx32[lpca_pkg::CMD_LEN_W-1:0];
                phase_next            = lpca_pkg::PH_HEADER;
                count_next            = '0;
                len_next              = '0;
                err_next              = lpca_pkg::CODE_OK;
                result.status_code    = lpca_pkg::CODE_OK;
            end
        end

        result.frame_done = (phase_next == lpca_pkg::PH_READY)
                            || (phase_next == lpca_pkg::PH_ERROR);
    end

    a_error_has_code: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == lpca_pkg::PH_ERROR |-> err_reg != lpca_pkg::CODE_OK)
        else $error("error phase without error code");

    a_code_only_in_error: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg != lpca_pkg::PH_ERROR |-> err_reg == lpca_pkg::CODE_OK)
        else $error("error code outside error phase");

    a_consume_clears: assert property (@(posedge clk) disable iff (!rst_n)
        accept && op == lpca_pkg::OP_CONSUME && phase_reg == lpca_pkg::PH_READY
        |=> phase_reg == lpca_pkg::PH_HEADER && count_reg == '0)
        else $error("consume of ready frame did not clear");

    a_header_count: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == lpca_pkg::PH_HEADER |-> count_reg < CNT_W'(HEADER_LEN))
        else $error("header count past header length");

endmodule

>>> rtl/lpca_out_reg.sv
module lpca_out_reg (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    output logic                load_ready,
    input  lpca_pkg::result_t   result_in,
    output logic                out_valid,
    input  logic                out_ready,
    output lpca_pkg::result_t   result_out
);

    logic               valid_reg, valid_next;
    lpca_pkg::result_t  data_reg;

    assign load_ready = !valid_reg || out_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= result_in;
        end
    end

    assign out_valid  = valid_reg;
    assign result_out = data_reg;

endmodule

>>> rtl/length_prefixed_command_assembler_unit.sv
// channel   direction  handshake            payload
// request   in         in_valid / in_ready  op, rx_byte
// result    out        out_valid/out_ready  store_*, frame_done, command_*, status_code
//
// one request per cycle while in_ready is high; its result is registered on acceptance and appears in the next cycle
// the result passes through the single result register after the frame state logic
// reset clears frame state to header collection and empties the result register
// a request is taken whenever the result register is empty or being drained
module length_prefixed_command_assembler_unit #(
    parameter int HEADER_LEN  = 10,
    parameter int MAX_CMD_LEN = 4096
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                op,
    input  logic [7:0]                          rx_byte,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                store_valid,
    output logic [lpca_pkg::INDEX_W-1:0]        store_index,
    output logic [7:0]                          store_data,
    output logic                                frame_done,
    output logic                                command_taken,
    output logic [lpca_pkg::CMD_LEN_W-1:0]      command_length,
    output logic [1:0]                          status_code
);

    logic               accept;
    lpca_pkg::result_t  step_result;
    lpca_pkg::result_t  held_result;

    assign accept = in_valid && in_ready;

    lpca_frame #(
        .HEADER_LEN  (HEADER_LEN),
        .MAX_CMD_LEN (MAX_CMD_LEN)
    ) u_frame (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .op      (op),
        .rx_byte (rx_byte),
        .result  (step_result)
    );

    lpca_out_reg u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (accept),
        .load_ready (in_ready),
        .result_in  (step_result),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .result_out (held_result)
    );

    assign store_valid    = held_result.store_valid;
    assign store_index    = held_result.store_index;
    assign store_data     = held_result.store_data;
    assign frame_done     = held_result.frame_done;
    assign command_taken  = held_result.command_taken;
    assign command_length = held_result.command_length;
    assign status_code    = held_result.status_code;

endmodule

>>> verif/tb.sv
`timescale 1ns / 100ps

module tb;

    localparam int HDR_BYTES   = 10;
    localparam int MAX_BYTES   = 4096;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        logic       op;
        logic [7:0] data;
    } request_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic op = lpca_pkg::OP_BYTE;
    logic [7:0] rx_byte = 8'h00;
    logic out_valid;
    logic out_ready = 1'b0;
    logic store_valid;
    logic [lpca_pkg::INDEX_W-1:0] store_index;
    logic [7:0] store_data;
    logic frame_done;
    logic command_taken;
    logic [lpca_pkg::CMD_LEN_W-1:0] command_length;
    logic [1:0] status_code;

    request_t pending_requests[$];
    lpca_pkg::result_t expected_reports[$];
    request_t next_req;
    lpca_pkg::result_t got_report;
    lpca_pkg::result_t want_report;

    lpca_pkg::phase_t asm_phase;
    logic [12:0] asm_count;
    logic [31:0] asm_length;
    logic [1:0] asm_code;

    int unsigned send_idle_pct = 0;
    int unsigned stall_pct = 0;
    int unsigned queued_count = 0;
    int unsigned fail_count = 0;
    int unsigned cycle_count = 0;

    length_prefixed_command_assembler_unit #(
        .HEADER_LEN (HDR_BYTES),
        .MAX_CMD_LEN(MAX_BYTES)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .op            (op),
        .rx_byte       (rx_byte),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .store_valid   (store_valid),
        .store_index   (store_index),
        .store_data    (store_data),
        .frame_done    (frame_done),
        .command_taken (command_taken),
        .command_length(command_length),
        .status_code   (status_code)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic lpca_pkg::result_t assemble_result(logic req_op, logic [7:0] b);
        lpca_pkg::result_t r;
        logic [12:0] idx;
        r = '0;
        if (req_op == lpca_pkg::OP_BYTE)
        begin
            if (asm_phase == lpca_pkg::PH_HEADER || asm_phase == lpca_pkg::PH_BODY)
            begin
                idx = asm_count;
                r.store_valid = 1'b1;
                r.store_index = idx[lpca_pkg::INDEX_W-1:0];
                r.store_data = b;
                asm_count = idx + 13'd1;
                if (asm_phase == lpca_pkg::PH_HEADER && idx >= lpca_pkg::LEN_FIRST
                    && idx <= lpca_pkg::LEN_LAST)
                    asm_length = {asm_length[23:0], b};
                if (asm_phase == lpca_pkg::PH_HEADER && asm_count == HDR_BYTES)
                begin
                    if (asm_length < HDR_BYTES)
                        asm_code = lpca_pkg::CODE_SMALL;
                    else if (asm_length > MAX_BYTES)
                        asm_code = lpca_pkg::CODE_LARGE;
                    else
                        asm_code = lpca_pkg::CODE_OK;
                    if (asm_code != lpca_pkg::CODE_OK)
                        asm_phase = lpca_pkg::PH_ERROR;
                    else if (asm_length == HDR_BYTES)
                        asm_phase = lpca_pkg::PH_READY;
                    else
                        asm_phase = lpca_pkg::PH_BODY;
                end
                else if (asm_phase == lpca_pkg::PH_BODY && asm_count == asm_length)
                begin
                    asm_phase = lpca_pkg::PH_READY;
                end
            end
            r.status_code = asm_code;
        end
        else
        begin
            r.status_code = asm_code;
            if (asm_phase == lpca_pkg::PH_READY)
            begin
                r.command_taken = 1'b1;
                r.command_length = asm_count;
                asm_phase = lpca_pkg::PH_HEADER;
                asm_count = '0;
                asm_length = '0;
                asm_code = lpca_pkg::CODE_OK;
                r.status_code = asm_code;
            end
        end
        r.frame_done = (asm_phase == lpca_pkg::PH_READY || asm_phase == lpca_pkg::PH_ERROR);
        return r;
    endfunction

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            op <= lpca_pkg::OP_BYTE;
            rx_byte <= 8'h00;
            asm_phase = lpca_pkg::PH_HEADER;
            asm_count = '0;
            asm_length = '0;
            asm_code = lpca_pkg::CODE_OK;
        end
        else
        begin
            if (in_valid && in_ready)
                expected_reports.push_back(assemble_result(op, rx_byte));
            if (!in_valid || in_ready)
            begin
                if (pending_requests.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    next_req = pending_requests.pop_front();
                    in_valid <= 1'b1;
                    op <= next_req.op;
                    rx_byte <= next_req.data;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= ($urandom_range(99) >= stall_pct);
            if (out_valid && out_ready)
            begin
                got_report = {store_valid, store_index, store_data, frame_done,
                              command_taken, command_length, status_code};
                if (expected_reports.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result: sv=%0d idx=%0d data=%02h", store_valid,
                                 store_index, store_data);
                end
                else
                begin
                    want_report = expected_reports.pop_front();
                    if (got_report !== want_report)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                        begin
                            $display("mismatch exp: sv=%0d idx=%0d data=%02h done=%0d",
                                     want_report.store_valid, want_report.store_index,
                                     want_report.store_data, want_report.frame_done);
                            $display("              taken=%0d len=%0d code=%0d",
                                     want_report.command_taken, want_report.command_length,
                                     want_report.status_code);
                            $display("         got: sv=%0d idx=%0d data=%02h done=%0d",
                                     store_valid, store_index, store_data, frame_done);
                            $display("              taken=%0d len=%0d code=%0d",
                                     command_taken, command_length, status_code);
                        end
                    end
                end
            end
        end
    end

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("length_prefixed_command_assembler_unit regression: fail");
        $finish;
    end

    task automatic push_request(input logic o, input logic [7:0] d);
        request_t r;
        r.op = o;
        r.data = d;
        pending_requests.push_back(r);
        queued_count++;
    endtask

    // fill < 0 gives random non-length bytes
    task automatic push_frame(input logic [31:0] len, input int fill, input bit noisy);
        logic [7:0] b;
        int unsigned last;
        last = (len >= HDR_BYTES && len <= MAX_BYTES) ? len : HDR_BYTES;
        for (int unsigned i = 0; i < last; i++)
        begin
            if (i >= lpca_pkg::LEN_FIRST && i <= lpca_pkg::LEN_LAST)
                b = 8'(len >> (8 * (lpca_pkg::LEN_LAST - i)));
            else if (fill < 0)
                b = 8'($urandom);
            else
                b = 8'(fill);
            if (noisy && $urandom_range(29) == 0)
                push_request(lpca_pkg::OP_CONSUME, 8'($urandom));
            push_request(lpca_pkg::OP_BYTE, b);
        end
    endtask

    task automatic close_frame();
        if ($urandom_range(3) == 0)
            repeat ($urandom_range(3, 1)) push_request(lpca_pkg::OP_BYTE, 8'($urandom));
        push_request(lpca_pkg::OP_CONSUME, 8'($urandom));
        if ($urandom_range(6) == 0)
            push_request(lpca_pkg::OP_CONSUME, 8'($urandom));
    endtask

    task automatic queue_random_frames(input int unsigned n_items, input bit with_longest);
        int unsigned goal;
        int unsigned pick;
        int unsigned len;
        goal = queued_count + n_items;
        while (queued_count < goal)
        begin
            pick = $urandom_range(19);
            if (pick < 2)
                len = HDR_BYTES;
            else if (pick == 2)
                len = $urandom_range(300, 31);
            else
                len = $urandom_range(30, HDR_BYTES + 1);
            push_frame(len, -1, 1'b1);
            close_frame();
            if (with_longest && queued_count * 2 >= goal)
            begin
                push_frame(MAX_BYTES, -1, 1'b1);
                close_frame();
                with_longest = 1'b0;
            end
        end
    endtask

    task automatic wait_drained();
        while (pending_requests.size() != 0 || in_valid)
            @(negedge clk);
    endtask

    initial
    begin
        logic [31:0] bad_len;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed
        push_request(lpca_pkg::OP_CONSUME, 8'hFF);
        push_frame(HDR_BYTES, 8'hFF, 1'b0);
        push_request(lpca_pkg::OP_BYTE, 8'h00);
        push_request(lpca_pkg::OP_CONSUME, 8'h00);
        push_request(lpca_pkg::OP_CONSUME, 8'hFF);
        push_frame(HDR_BYTES + 2, 8'h00, 1'b0);
        push_request(lpca_pkg::OP_CONSUME, 8'h00);
        wait_drained();

        queue_random_frames(170, 1'b0);
        wait_drained();

        send_idle_pct = 60;
        stall_pct = 0;
        queue_random_frames(170, 1'b0);
        wait_drained();

        send_idle_pct = 0;
        stall_pct = 60;
        queue_random_frames(170, 1'b0);
        wait_drained();

        send_idle_pct = 35;
        stall_pct = 35;
        queue_random_frames(170, 1'b0);

        // a bad length locks the block in error for the rest of the run
        if ($urandom_range(1) == 0)
            bad_len = $urandom_range(HDR_BYTES - 1, 0);
        else if ($urandom_range(1) == 0)
            bad_len = MAX_BYTES + 1;
        else
            bad_len = $urandom_range(32'hFFFF_FFFF, MAX_BYTES + 1);
        push_frame(bad_len, -1, 1'b0);
        push_request(lpca_pkg::OP_BYTE, 8'($urandom));
        push_request(lpca_pkg::OP_CONSUME, 8'($urandom));
        push_request(lpca_pkg::OP_BYTE, 8'($urandom));
        push_request(lpca_pkg::OP_CONSUME, 8'($urandom));
        wait_drained();

        while (expected_reports.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);

        if (fail_count == 0)
            $display("length_prefixed_command_assembler_unit regression: pass");
        else
            $display("length_prefixed_command_assembler_unit regression: fail");
        $finish;
    end

endmodule
